>>> rtl/core/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debouncer with long press.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int unsigned DEB_W  = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 32;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 16'd50;
	localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd5000;

	// configuration register indexes
	localparam logic CFG_DEBOUNCE   = 1'b0;
	localparam logic CFG_LONG_PRESS = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE          = 3'd0,
		PH_DEB_PRESS     = 3'd1,
		PH_PRESSED       = 3'd2,
		PH_LONG          = 3'd3,
		PH_DEB_SHORT_REL = 3'd4,
		PH_DEB_LONG_REL  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [DEB_W-1:0]  debounce_ms;
		logic [TIME_W-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] now_ms;
		logic              lamp_on;
	} sample_t;

	typedef struct packed {
		logic       lamp_on_next;
		logic       short_press;
		logic       long_press;
		logic [2:0] phase_now;
	} result_t;

endpackage

>>> rtl/core/bdlp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_cfg
// Configuration registers: debounce time and long-press time.
// ----------------------------------------------------------------------------
module bdlp_cfg
	import bdlp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	logic [DEB_W-1:0]  debounce_q;
	logic [TIME_W-1:0] long_press_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: begin
					debounce_q <= cfg_data[DEB_W-1:0];
				end
				CFG_LONG_PRESS: begin
					long_press_q <= cfg_data[TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.debounce_ms   = debounce_q;
	assign cfg.long_press_ms = long_press_q;

endmodule

>>> rtl/core/bdlp_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_fsm
// Six-phase press/release machine; state advances once per request.
// ----------------------------------------------------------------------------
module bdlp_fsm
	import bdlp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  sample_t smp,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t            phase_q, phase_d;
	logic              prev_level_q;
	logic [TIME_W-1:0] mark_q, mark_d;
	logic [TIME_W-1:0] confirm_q, confirm_d;
	logic [TIME_W-1:0] since;
	logic [TIME_W-1:0] limit;
	logic              expired;
	logic              short_ev, long_ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			prev_level_q <= 1'b1;
			mark_q       <= '0;
			confirm_q    <= '0;
		end else if (adv) begin
			phase_q      <= phase_d;
			prev_level_q <= smp.level;
			mark_q       <= mark_d;
			confirm_q    <= confirm_d;
		end
	end

	// one elapsed-time compare, reference picked by phase
	always_comb begin
		if (phase_q == PH_PRESSED) begin
			since = confirm_q;
			limit = cfg.long_press_ms;
		end else begin
			since = mark_q;
			limit = {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_ms};
		end
		expired = (smp.now_ms - since) >= limit;
	end

	always_comb begin
		phase_d   = phase_q;
		mark_d    = mark_q;
		confirm_d = confirm_q;
		short_ev  = 1'b0;
		long_ev   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (prev_level_q && !smp.level) begin
					phase_d = PH_DEB_PRESS;
					mark_d  = smp.now_ms;
				end
			end
			PH_DEB_PRESS: begin
				if (smp.level) begin
					phase_d = PH_IDLE;
				end else if (expired) begin
					phase_d   = PH_PRESSED;
					confirm_d = smp.now_ms;
				end
			end
			PH_PRESSED: begin
				if (smp.level) begin
					phase_d = PH_DEB_SHORT_REL;
					mark_d  = smp.now_ms;
				end else if (expired) begin
					phase_d = PH_LONG;
					long_ev = 1'b1;
				end
			end
			PH_LONG: begin
				if (smp.level) begin
					phase_d = PH_DEB_LONG_REL;
					mark_d  = smp.now_ms;
				end
			end
			PH_DEB_SHORT_REL: begin
				if (!smp.level) begin
					phase_d = PH_PRESSED;
				end else if (expired) begin
					phase_d  = PH_IDLE;
					short_ev = 1'b1;
				end
			end
			PH_DEB_LONG_REL: begin
				if (!smp.level) begin
					phase_d = PH_LONG;
				end else if (expired) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign res.lamp_on_next = smp.lamp_on ^ short_ev;
	assign res.short_press  = short_ev;
	assign res.long_press   = long_ev;
	assign res.phase_now    = phase_d;

endmodule

>>> rtl/core/button_debounce_long_press_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_top
// Debounced push button with long-press event and short-press lamp toggle.
// Each request is held in the input register, then the result register.
// Throughput: one request per cycle unless out_stall holds back the output.
// Reset: asynchronous, active low; idle phase, button released,
// debounce 50 ms, long press 5000 ms, both pipeline stages empty.
// ----------------------------------------------------------------------------
module button_debounce_long_press_top
	import bdlp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              level,
	input  logic [TIME_W-1:0] now_ms,
	input  logic              lamp_on,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              lamp_on_next,
	output logic              short_press,
	output logic              long_press,
	output logic [2:0]        phase_now
);

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;
	logic    in_acc;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_s1.level   <= level;
			smp_s1.now_ms  <= now_ms;
			smp_s1.lamp_on <= lamp_on;
		end
	end

	bdlp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdlp_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.smp    (smp_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign lamp_on_next = res_s2.lamp_on_next;
	assign short_press  = res_s2.short_press;
	assign long_press   = res_s2.long_press;
	assign phase_now    = res_s2.phase_now;

endmodule

>>> dv/button_debounce_long_press_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_top_test
// Checks the debouncer one request at a time against an in-bench model of the
// press/release phases. A short walk through press bounce, short release,
// counter wrap, long press and backwards time runs first at reset settings,
// then gesture-shaped random traffic with noise under several register
// settings, the extremes among them, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module button_debounce_long_press_top_test;
	import bdlp_pkg::*;

	typedef struct packed {
		logic              lvl;
		logic [TIME_W-1:0] t;
		logic              lamp;
		logic              pinned;
		result_t           want;
	} step_row_t;

	localparam int NROWS = 22;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              level;
	logic [TIME_W-1:0] now_ms;
	logic              lamp_on;
	logic              out_valid;
	logic              out_stall;
	logic              lamp_on_next;
	logic              short_press;
	logic              long_press;
	logic [2:0]        phase_now;

	button_debounce_long_press_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.level        (level),
		.now_ms       (now_ms),
		.lamp_on      (lamp_on),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.lamp_on_next (lamp_on_next),
		.short_press  (short_press),
		.long_press   (long_press),
		.phase_now    (phase_now)
	);

	// button model state and its copy of the registers
	phase_t            btn_phase;
	logic              btn_prev_lvl;
	logic [TIME_W-1:0] btn_mark_t;
	logic [TIME_W-1:0] btn_confirm_t;
	logic [DEB_W-1:0]  debounce_set;
	logic [TIME_W-1:0] long_press_set;

	result_t           pending_results[$];
	int                fail_count;
	int                requests_sent;
	bit                idle_on;
	int                stall_left;
	logic [TIME_W-1:0] clock_ms;

	step_row_t walk [NROWS] = '{
		'{1'b1, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, PH_IDLE}},
		'{1'b0, 32'd100,       1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, PH_DEB_PRESS}},
		'{1'b0, 32'd120,       1'b0, 1'b0, '0},
		'{1'b1, 32'd130,       1'b1, 1'b0, '0},
		'{1'b0, 32'd200,       1'b0, 1'b0, '0},
		'{1'b0, 32'd250,       1'b1, 1'b0, '0},
		'{1'b1, 32'd260,       1'b0, 1'b0, '0},
		'{1'b0, 32'd270,       1'b1, 1'b0, '0},
		'{1'b1, 32'd280,       1'b0, 1'b0, '0},
		'{1'b1, 32'd330,       1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, PH_IDLE}},
		'{1'b0, 32'hFFFF_FF00, 1'b0, 1'b0, '0},
		'{1'b0, 32'h0000_0010, 1'b1, 1'b0, '0},
		'{1'b0, 32'h0000_1397, 1'b0, 1'b0, '0},
		'{1'b0, 32'h0000_1398, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, PH_LONG}},
		'{1'b0, 32'h0000_2000, 1'b1, 1'b0, '0},
		'{1'b1, 32'h0000_2010, 1'b0, 1'b0, '0},
		'{1'b0, 32'h0000_2020, 1'b1, 1'b0, '0},
		'{1'b1, 32'h0000_2030, 1'b0, 1'b0, '0},
		'{1'b1, 32'h0000_2000, 1'b1, 1'b0, '0},
		'{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
		'{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
		'{1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, PH_IDLE}}
	};

	function automatic result_t next_button_result(input sample_t s);
		result_t           r;
		logic              short_ev;
		logic              long_ev;
		logic [TIME_W-1:0] since_mark;
		logic [TIME_W-1:0] since_confirm;
		short_ev      = 1'b0;
		long_ev       = 1'b0;
		since_mark    = s.now_ms - btn_mark_t;
		since_confirm = s.now_ms - btn_confirm_t;
		case (btn_phase)
			PH_IDLE: begin
				if (btn_prev_lvl && !s.level) begin
					btn_phase  = PH_DEB_PRESS;
					btn_mark_t = s.now_ms;
				end
			end
			PH_DEB_PRESS: begin
				if (s.level) begin
					btn_phase = PH_IDLE;
				end else if (since_mark >= TIME_W'(debounce_set)) begin
					btn_phase     = PH_PRESSED;
					btn_confirm_t = s.now_ms;
				end
			end
			PH_PRESSED: begin
				if (s.level) begin
					btn_phase  = PH_DEB_SHORT_REL;
					btn_mark_t = s.now_ms;
				end else if (since_confirm >= long_press_set) begin
					btn_phase = PH_LONG;
					long_ev   = 1'b1;
				end
			end
			PH_LONG: begin
				if (s.level) begin
					btn_phase  = PH_DEB_LONG_REL;
					btn_mark_t = s.now_ms;
				end
			end
			PH_DEB_SHORT_REL: begin
				if (!s.level) begin
					btn_phase = PH_PRESSED;
				end else if (since_mark >= TIME_W'(debounce_set)) begin
					btn_phase = PH_IDLE;
					short_ev  = 1'b1;
				end
			end
			PH_DEB_LONG_REL: begin
				if (!s.level) begin
					btn_phase = PH_LONG;
				end else if (since_mark >= TIME_W'(debounce_set)) begin
					btn_phase = PH_IDLE;
				end
			end
			default: begin
				btn_phase = PH_IDLE;
			end
		endcase
		btn_prev_lvl   = s.level;
		r.lamp_on_next = s.lamp_on ^ short_ev;
		r.short_press  = short_ev;
		r.long_press   = long_ev;
		r.phase_now    = btn_phase;
		return r;
	endfunction

	// a step near a threshold: well under, one short, exact, or a little over
	function automatic logic [TIME_W-1:0] near_gap(input logic [TIME_W-1:0] thr);
		logic [TIME_W-1:0] g;
		case ($urandom_range(0, 3))
			0:       g = $urandom_range(0, thr / 3);
			1:       g = thr - 1;
			2:       g = thr;
			default: g = thr + $urandom_range(0, 40);
		endcase
		return g;
	endfunction

	task automatic send_sample(input sample_t s, input bit pinned, input result_t pinned_res);
		result_t r;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		level    <= s.level;
		now_ms   <= s.now_ms;
		lamp_on  <= s.lamp_on;
		do @(posedge clk); while (in_stall);
		r = next_button_result(s);
		pending_results.push_back(pinned ? pinned_res : r);
		requests_sent++;
	endtask

	task automatic emit(input logic lvl, input logic [TIME_W-1:0] delta);
		sample_t s;
		clock_ms  = clock_ms + delta;
		s.level   = lvl;
		s.now_ms  = clock_ms;
		s.lamp_on = 1'($urandom_range(0, 1));
		send_sample(s, 1'b0, '0);
	endtask

	function automatic logic [TIME_W-1:0] tiny_gap();
		return $urandom_range(0, debounce_set / 4 + 1);
	endfunction

	task automatic press_gesture();
		int      holds;
		sample_t s;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				s.level   = 1'($urandom_range(0, 1));
				s.now_ms  = $urandom;
				s.lamp_on = 1'($urandom_range(0, 1));
				clock_ms  = s.now_ms;
				send_sample(s, 1'b0, '0);
			end
		end
		repeat ($urandom_range(0, 2)) emit(1'b1, tiny_gap());
		repeat ($urandom_range(0, 2)) begin
			emit(1'b0, tiny_gap());
			emit(1'b1, tiny_gap());
		end
		emit(1'b0, tiny_gap());
		emit(1'b0, near_gap(TIME_W'(debounce_set)));
		holds = $urandom_range(0, 4);
		repeat (holds) begin
			if ($urandom_range(0, 1))
				emit(1'b0, near_gap(long_press_set));
			else
				emit(1'b0, near_gap(TIME_W'(debounce_set)));
		end
		repeat ($urandom_range(0, 2)) begin
			emit(1'b1, tiny_gap());
			emit(1'b0, tiny_gap());
		end
		emit(1'b1, tiny_gap());
		emit(1'b1, near_gap(TIME_W'(debounce_set)));
		if ($urandom_range(0, 1))
			emit(1'b1, near_gap(TIME_W'(debounce_set)));
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEBOUNCE)
			debounce_set = val[DEB_W-1:0];
		else
			long_press_set = val;
		@(posedge clk);
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				if (stall_left == 0)
					out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall  <= 1'b1;
				stall_left = $urandom_range(1, 8);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: phase_now %0d", phase_now);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (lamp_on_next !== want.lamp_on_next) begin
					$error("lamp_on_next: expected %0d, got %0d", want.lamp_on_next, lamp_on_next);
					fail_count++;
				end
				if (short_press !== want.short_press) begin
					$error("short_press: expected %0d, got %0d", want.short_press, short_press);
					fail_count++;
				end
				if (long_press !== want.long_press) begin
					$error("long_press: expected %0d, got %0d", want.long_press, long_press);
					fail_count++;
				end
				if (phase_now !== want.phase_now) begin
					$error("phase_now: expected %0d, got %0d", want.phase_now, phase_now);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		sample_t          s;
		logic [DEB_W-1:0] deb_pick;
		logic [TIME_W-1:0] long_pick;
		int               quota;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_DEBOUNCE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		level          = 1'b1;
		now_ms         = '0;
		lamp_on        = 1'b0;
		fail_count     = 0;
		requests_sent  = 0;
		idle_on        = 1'b1;
		btn_phase      = PH_IDLE;
		btn_prev_lvl   = 1'b1;
		btn_mark_t     = '0;
		btn_confirm_t  = '0;
		debounce_set   = DEBOUNCE_RST;
		long_press_set = LONG_PRESS_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NROWS; i++) begin
			s.level   = walk[i].lvl;
			s.now_ms  = walk[i].t;
			s.lamp_on = walk[i].lamp;
			send_sample(s, walk[i].pinned, walk[i].want);
		end
		clock_ms = walk[NROWS-1].t;

		for (int ph = 0; ph < 6; ph++) begin
			wait_empty();
			case (ph)
				0: begin deb_pick = '0;     long_pick = '0;           quota = 130; end
				1: begin deb_pick = '1;     long_pick = '1;           quota = 130; end
				2: begin deb_pick = 16'd20; long_pick = 32'd300;      quota = 250; end
				3: begin deb_pick = 16'd1;  long_pick = 32'd4;        quota = 180; end
				4: begin
					deb_pick  = 16'($urandom_range(0, 200));
					long_pick = $urandom_range(0, 2000);
					quota     = 180;
				end
				default: begin
					deb_pick = DEBOUNCE_RST; long_pick = LONG_PRESS_RST; quota = 180;
				end
			endcase
			write_reg(CFG_DEBOUNCE, CFG_W'(deb_pick));
			write_reg(CFG_LONG_PRESS, long_pick);
			quota = requests_sent + quota;
			while (requests_sent < quota) begin
				idle_on = (ph != 5) && ($urandom_range(0, 3) != 0);
				press_gesture();
			end
		end

		idle_on = 1'b0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_cfg.sv
rtl/core/bdlp_fsm.sv
rtl/core/button_debounce_long_press_top.sv
dv/button_debounce_long_press_top_test.sv
